FILE: design/pspc_pkg.sv
package pspc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LIMIT_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LIMIT_Y = 1'd1;

  // Field widths
  localparam int unsigned COORD_W = 11;
  localparam int unsigned STATUS_W = 2;

  // Register reset values
  localparam logic [COORD_W-1:0] SPAN_LIMIT_X_RST = 11'd1023;
  localparam logic [COORD_W-1:0] SPAN_LIMIT_Y_RST = 11'd511;

  // Bounds reload values at each command word
  localparam logic signed [COORD_W-1:0] COORD_MAX = 11'sh3FF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 11'sh400;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_NOT_POLY = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHECKED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;

  // Polygon opcode range and flag bits
  localparam logic [7:0] OP_POLY_FIRST = 8'h20;
  localparam logic [7:0] OP_POLY_LAST  = 8'h3F;
  localparam int unsigned OP_BIT_TEX  = 2;
  localparam int unsigned OP_BIT_QUAD = 3;
  localparam int unsigned OP_BIT_GOUR = 4;

  // Decoded polygon command
  typedef struct packed {
    logic gour;
    logic tex;
    logic quad;
    logic poly;
  } poly_flags_t;

  // Work handed from the parser to the bounds unit
  typedef struct packed {
    logic                       clear;
    logic                       vertex;
    logic                       last;
    logic [STATUS_W-1:0]        status;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } pspc_job_t;

  // One result
  typedef struct packed {
    logic                exceeds;
    logic [STATUS_W-1:0] status;
  } pspc_res_t;

endpackage

FILE: design/pspc_fifo.sv
module pspc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/pspc_front.sv
module pspc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [31:0]         word_i,
  input  logic                last_i,
  output pspc_pkg::pspc_job_t job_o
);

  import pspc_pkg::*;

  logic        at_start_q, at_start_d;
  poly_flags_t flags_q, flags_d;
  logic [2:0]  vseen_q, vseen_d;
  logic [1:0]  skip_q, skip_d;
  logic [7:0]  opcode;
  logic [2:0]  needed;

  assign opcode = word_i[31:24];
  assign needed = flags_d.quad ? 3'd4 : 3'd3;

  // Word classification and parser state
  always_comb begin
    flags_d      = flags_q;
    vseen_d      = vseen_q;
    skip_d       = skip_q;
    job_o.clear  = 1'b0;
    job_o.vertex = 1'b0;
    job_o.last   = last_i;
    job_o.x      = word_i[COORD_W-1:0];
    job_o.y      = word_i[16 +: COORD_W];
    if (at_start_q) begin
      // command word: decode opcode, reload bounds
      flags_d = '0;
      if (opcode inside {[OP_POLY_FIRST:OP_POLY_LAST]}) begin
        flags_d.poly = 1'b1;
        flags_d.quad = opcode[OP_BIT_QUAD];
        flags_d.tex  = opcode[OP_BIT_TEX];
        flags_d.gour = opcode[OP_BIT_GOUR];
      end
      vseen_d     = '0;
      skip_d      = '0;
      job_o.clear = 1'b1;
    end else if (flags_q.poly && (vseen_q < (flags_q.quad ? 3'd4 : 3'd3))) begin
      if (skip_q == '0) begin
        job_o.vertex = 1'b1;
        vseen_d      = vseen_q + 3'd1;
        skip_d       = {1'b0, flags_q.tex} + {1'b0, flags_q.gour};
      end else begin
        skip_d = skip_q - 2'd1;
      end
    end
    // status only matters on the last word
    if (!flags_d.poly) begin
      job_o.status = STATUS_NOT_POLY;
    end else if (vseen_d < needed) begin
      job_o.status = STATUS_SHORT;
    end else begin
      job_o.status = STATUS_CHECKED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      flags_q    <= '0;
      vseen_q    <= '0;
      skip_q     <= '0;
    end else if (take_i) begin
      at_start_q <= last_i;
      flags_q    <= flags_d;
      vseen_q    <= vseen_d;
      skip_q     <= skip_d;
    end
  end

endmodule

FILE: design/pspc_back.sv
module pspc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  pspc_pkg::pspc_job_t job_i,
  output logic                job_pop_o,
  input  logic [10:0]         span_limit_x_i,
  input  logic [10:0]         span_limit_y_i,
  input  logic                res_full_i,
  output logic                res_push_o,
  output pspc_pkg::pspc_res_t res_o
);

  import pspc_pkg::*;

  logic signed [COORD_W-1:0] least_x_q, least_x_d;
  logic signed [COORD_W-1:0] least_y_q, least_y_d;
  logic signed [COORD_W-1:0] great_x_q, great_x_d;
  logic signed [COORD_W-1:0] great_y_q, great_y_d;
  logic signed [COORD_W:0]   span_x, span_y;
  logic                      over;

  // Consume a job whenever the result queue has room
  assign job_pop_o  = job_valid_i && !res_full_i;
  assign res_push_o = job_pop_o && job_i.last;

  // Bounds update
  always_comb begin
    least_x_d = least_x_q;
    least_y_d = least_y_q;
    great_x_d = great_x_q;
    great_y_d = great_y_q;
    if (job_i.clear) begin
      least_x_d = COORD_MAX;
      least_y_d = COORD_MAX;
      great_x_d = COORD_MIN;
      great_y_d = COORD_MIN;
    end else if (job_i.vertex) begin
      if (job_i.x < least_x_q) least_x_d = job_i.x;
      if (job_i.y < least_y_q) least_y_d = job_i.y;
      if (job_i.x > great_x_q) great_x_d = job_i.x;
      if (job_i.y > great_y_q) great_y_d = job_i.y;
    end
  end

  // Span check against the limits
  always_comb begin
    span_x = {great_x_d[COORD_W-1], great_x_d} - {least_x_d[COORD_W-1], least_x_d};
    span_y = {great_y_d[COORD_W-1], great_y_d} - {least_y_d[COORD_W-1], least_y_d};
    over   = (span_x > $signed({1'b0, span_limit_x_i}))
          || (span_y > $signed({1'b0, span_limit_y_i}));
    res_o.status  = job_i.status;
    res_o.exceeds = (job_i.status == STATUS_CHECKED) && over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_x_q <= COORD_MAX;
      least_y_q <= COORD_MAX;
      great_x_q <= COORD_MIN;
      great_y_q <= COORD_MIN;
    end else if (job_pop_o) begin
      least_x_q <= least_x_d;
      least_y_q <= least_y_d;
      great_x_q <= great_x_d;
      great_y_q <= great_y_d;
    end
  end

endmodule

FILE: design/polygon_packet_span_check.sv
// Polygon packet span check.
// Input channel: one 32-bit packet word per transfer on word_i with last_i
// marking the final word; a transfer happens when push is high and full low.
// Result channel: one result per packet (exceeds_o, status_o), available
// while empty is low and taken when pop is high.
// Configuration: cfg_we_i writes register cfg_idx_i (0 x, 1 y span limit)
// from cfg_data_i at the clock edge. Write only while idle; not enforced.
// Throughput: one word per cycle while full is low. The parser classifies
// each word as it is taken and queues it; the bounds unit folds one queued
// word per cycle while the result queue is not full. The result of a packet
// is registered in the job queue after its last word is taken; the bounds
// unit then writes it into the result queue directly, where it is popped.
// When the receiver stalls, the result queue fills, then the job queue, and
// full rises; no word or result is dropped.
// Reset (rst_ni low, asynchronous) empties both queues, restores the
// limits to 1023 and 511, and expects a command word next.
module polygon_packet_span_check #(
  parameter int unsigned JOB_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [31:0]                        word_i,
  input  logic                               last_i,
  output logic                               empty,
  input  logic                               pop,
  output logic                               exceeds_o,
  output logic [1:0]                         status_o,
  input  logic                               cfg_we_i,
  input  logic [pspc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [10:0]                        cfg_data_i
);

  import pspc_pkg::*;

  logic [COORD_W-1:0] span_limit_x_q, span_limit_y_q;
  logic               take;
  pspc_job_t          job_in, job_out;
  logic               job_empty, job_pop;
  pspc_res_t          res_in, res_out;
  logic               res_full, res_push;

  assign take = push && !full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_limit_x_q <= SPAN_LIMIT_X_RST;
      span_limit_y_q <= SPAN_LIMIT_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPAN_LIMIT_X: span_limit_x_q <= cfg_data_i;
        REG_SPAN_LIMIT_Y: span_limit_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser
  pspc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .word_i (word_i),
    .last_i (last_i),
    .job_o  (job_in)
  );

  // Job queue between parser and bounds unit
  pspc_fifo #(
    .WIDTH ($bits(pspc_job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Bounds tracking and span compare
  pspc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .span_limit_x_i (span_limit_x_q),
    .span_limit_y_i (span_limit_y_q),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_in)
  );

  // Result queue
  pspc_fifo #(
    .WIDTH ($bits(pspc_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign exceeds_o = res_out.exceeds;
  assign status_o  = res_out.status;

  // Only a checked polygon can report an exceeded span
  a_exceeds_only_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && exceeds_o |-> status_o == STATUS_CHECKED)
    else $error("span exceeded reported without a polygon check");

  // A packet end taken into idle queues shows up in the result queue
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last_i && job_empty && empty |=> ##1 !empty)
    else $error("packet result did not appear in time");

  // The bounds unit never consumes a job it cannot place a result for
  a_no_result_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full && !pop |=> !res_push || res_full && $past(res_full))
    else $error("result queue overflow");

endmodule
